FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sample on clk_i and are off while rst_ni is low.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant violated");

`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication violated");

`define ASSERT_DELAYED(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("delayed implication violated");

`endif

FILE: design/wcg_pkg.sv
package wcg_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int LEN_W      = $clog2(MAX_LENGTH);
  localparam int PHASE_W    = 16;
  localparam int CW         = 32;
  localparam int STEPS      = 16;
  localparam int STEP_W     = $clog2(STEPS);
  localparam int NUM_LANES  = 3;
  localparam int COS_W      = 18;
  localparam int COEF_W     = 17;
  localparam int PROD_W     = COS_W + COEF_W;
  localparam int SUM_W      = 36;
  localparam int WEIGHT_W   = 17;
  localparam int REG_W      = 1;
  localparam int CFG_W      = LEN_W;
  localparam int COS_SHIFT  = 14;
  localparam int SUM_SHIFT  = 16;
  localparam int LATENCY    = PHASE_W + STEPS + 6;

  localparam logic [REG_W-1:0] REG_WINDOW_KIND = 1'b0;
  localparam logic [REG_W-1:0] REG_LENGTH      = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1023);

  typedef enum logic [1:0] {
    KIND_RECT    = 2'd0,
    KIND_BN      = 2'd1,
    KIND_HAMMING = 2'd2,
    KIND_HANN    = 2'd3
  } kind_e;

  localparam logic signed [CW-1:0] CORDIC_X0  = 32'sd652032874;
  localparam logic signed [CW-1:0] Z_LIMIT    = 32'sh4000_0000;
  localparam logic signed [CW-1:0] COS_ROUND  = 32'sd8192;
  localparam logic signed [CW-1:0] COS_CLAMP  = 32'sd65536;

  localparam logic signed [COEF_W-1:0] BN_A1 = 17'sd32059;
  localparam logic signed [COEF_W-1:0] BN_A2 = 17'sd8952;
  localparam logic signed [COEF_W-1:0] BN_A3 = 17'sd697;
  localparam logic signed [COEF_W-1:0] HM_A1 = 17'sd30254;

  localparam logic signed [SUM_W-1:0] BN_BASE   = SUM_W'(longint'(23828) * longint'(65536));
  localparam logic signed [SUM_W-1:0] HM_BASE   = SUM_W'(longint'(35282) * longint'(65536));
  localparam logic signed [SUM_W-1:0] SUM_ROUND = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] SUM_CLAMP = SUM_W'(65536);

  localparam logic signed [COS_W:0] HANN_BASE = 19'sd65537;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [CW-1:0] ATAN_TURNS [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic  oor;
    logic  at_end;
    kind_e kind;
  } ctl_t;

  typedef struct packed {
    logic [LEN_W-1:0]   divisor;
    logic [LEN_W-1:0]   rem;
    logic [PHASE_W-1:0] num;
    logic [PHASE_W-1:0] quot;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] lanes_t;

  // Fold the angle into [-1/4, 1/4) turn and seed the rotation.
  function automatic lane_t lane_init(input logic [PHASE_W-1:0] ph);
    lane_t r;
    logic  fold;
    fold  = ph[PHASE_W-1] ^ ph[PHASE_W-2];
    r.x   = CORDIC_X0;
    r.y   = '0;
    r.z   = $signed({ph[PHASE_W-1] ^ fold, ph[PHASE_W-2:0], {(CW-PHASE_W){1'b0}}});
    r.neg = fold;
    return r;
  endfunction

endpackage

FILE: design/wcg_div_cell.sv
`include "assert_macros.svh"

module wcg_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  wcg_pkg::ctl_t ctl_i,
  input  wcg_pkg::div_t div_i,
  output logic          vld_o,
  output wcg_pkg::ctl_t ctl_o,
  output wcg_pkg::div_t div_o
);
  import wcg_pkg::*;

  logic [LEN_W:0] rem_wide;
  logic [LEN_W:0] diff;
  logic           take;
  div_t           div_d;
  div_t           div_q;
  ctl_t           ctl_q;
  logic           vld_q;

  always_comb begin
    rem_wide     = {div_i.rem, div_i.num[PHASE_W-1]};
    diff         = rem_wide - {1'b0, div_i.divisor};
    take         = rem_wide >= {1'b0, div_i.divisor};
    div_d.divisor = div_i.divisor;
    div_d.rem    = take ? diff[LEN_W-1:0] : rem_wide[LEN_W-1:0];
    div_d.num    = {div_i.num[PHASE_W-2:0], 1'b0};
    div_d.quot   = {div_i.quot[PHASE_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    ctl_q <= ctl_i;
  end

  assign vld_o = vld_q;
  assign ctl_o = ctl_q;
  assign div_o = div_q;

  `ASSERT_IMPLIES(a_rem_below_divisor, vld_q && (div_q.divisor != '0), div_q.rem < div_q.divisor)

endmodule

FILE: design/wcg_cordic_cell.sv
`include "assert_macros.svh"

module wcg_cordic_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wcg_pkg::STEP_W-1:0] step_i,
  input  logic                       vld_i,
  input  wcg_pkg::ctl_t              ctl_i,
  input  wcg_pkg::lanes_t            lanes_i,
  output logic                       vld_o,
  output wcg_pkg::ctl_t              ctl_o,
  output wcg_pkg::lanes_t            lanes_o
);
  import wcg_pkg::*;

  logic signed [CW-1:0] atan;
  lanes_t               lanes_d;
  lanes_t               lanes_q;
  ctl_t                 ctl_q;
  logic                 vld_q;

  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    atan    = $signed(ATAN_TURNS[step_i]);
    lanes_d = lanes_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      dx = $signed(lanes_i[l].y) >>> step_i;
      dy = $signed(lanes_i[l].x) >>> step_i;
      if (!lanes_i[l].z[CW-1]) begin
        lanes_d[l].x = lanes_i[l].x - dx;
        lanes_d[l].y = lanes_i[l].y + dy;
        lanes_d[l].z = lanes_i[l].z - atan;
      end else begin
        lanes_d[l].x = lanes_i[l].x + dx;
        lanes_d[l].y = lanes_i[l].y - dy;
        lanes_d[l].z = lanes_i[l].z + atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    ctl_q   <= ctl_i;
  end

  assign vld_o   = vld_q;
  assign ctl_o   = ctl_q;
  assign lanes_o = lanes_q;

  `ASSERT_IMPLIES(a_angle_bounded, vld_q, ($signed(lanes_q[0].z) <= Z_LIMIT) && ($signed(lanes_q[0].z) >= -Z_LIMIT))

endmodule

FILE: design/wcg_weight.sv
module wcg_weight (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  wcg_pkg::ctl_t                ctl_i,
  input  wcg_pkg::lanes_t              lanes_i,
  output logic                         done_o,
  output logic [wcg_pkg::WEIGHT_W-1:0] weight_o,
  output logic                         oor_o
);
  import wcg_pkg::*;

  logic signed [COS_W-1:0]  cos_d [NUM_LANES];
  logic signed [COS_W-1:0]  cos_q [NUM_LANES];
  ctl_t                     ctl_c_q;
  logic                     vld_c_q;

  logic signed [COEF_W-1:0] k1;
  logic signed [PROD_W-1:0] m1_d, m2_d, m3_d;
  logic signed [PROD_W-1:0] m1_q, m2_q, m3_q;
  logic signed [COS_W-1:0]  c1_m_q;
  ctl_t                     ctl_m_q;
  logic                     vld_m_q;

  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [COS_W-1:0]  c1_s_q;
  ctl_t                     ctl_s_q;
  logic                     vld_s_q;

  logic signed [SUM_W-1:0]  rounded;
  logic signed [COS_W:0]    hann;
  logic [WEIGHT_W-1:0]      weight_d;
  logic [WEIGHT_W-1:0]      weight_q;
  logic                     oor_q;
  logic                     done_q;

  always_comb begin
    logic signed [CW-1:0] xr;
    for (int l = 0; l < NUM_LANES; l++) begin
      xr = ($signed(lanes_i[l].x) + COS_ROUND) >>> COS_SHIFT;
      if (xr > COS_CLAMP) begin
        xr = COS_CLAMP;
      end else if (xr < -COS_CLAMP) begin
        xr = -COS_CLAMP;
      end
      cos_d[l] = lanes_i[l].neg ? COS_W'(-xr) : COS_W'(xr);
    end
  end

  always_comb begin
    k1   = (ctl_c_q.kind == KIND_BN) ? BN_A1 : HM_A1;
    m1_d = k1 * cos_q[0];
    m2_d = BN_A2 * cos_q[1];
    m3_d = BN_A3 * cos_q[2];
  end

  always_comb begin
    if (ctl_m_q.kind == KIND_BN) begin
      sum_d = BN_BASE - SUM_W'(m1_q) + SUM_W'(m2_q) - SUM_W'(m3_q);
    end else begin
      sum_d = HM_BASE - SUM_W'(m1_q);
    end
  end

  always_comb begin
    rounded = (sum_q + SUM_ROUND) >>> SUM_SHIFT;
    hann    = HANN_BASE - (COS_W+1)'(c1_s_q);
    unique case (ctl_s_q.kind) inside
      KIND_RECT: begin
        weight_d = ONE_Q16;
      end
      KIND_BN, KIND_HAMMING: begin
        if (sum_q < 0) begin
          weight_d = '0;
        end else if (rounded > SUM_CLAMP) begin
          weight_d = ONE_Q16;
        end else begin
          weight_d = rounded[WEIGHT_W-1:0];
        end
      end
      default: begin
        weight_d = hann[WEIGHT_W:1];
      end
    endcase
    if (ctl_s_q.oor) begin
      weight_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_m_q <= 1'b0;
      vld_s_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_c_q <= vld_i;
      vld_m_q <= vld_c_q;
      vld_s_q <= vld_m_q;
      done_q  <= vld_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q    <= cos_d;
    ctl_c_q  <= ctl_i;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    m3_q     <= m3_d;
    c1_m_q   <= cos_q[0];
    ctl_m_q  <= ctl_c_q;
    sum_q    <= sum_d;
    c1_s_q   <= c1_m_q;
    ctl_s_q  <= ctl_m_q;
    weight_q <= weight_d;
    oor_q    <= ctl_s_q.oor;
  end

  assign done_o   = done_q;
  assign weight_o = weight_q;
  assign oor_o    = oor_q;

endmodule

FILE: design/window_coefficient_generator.sv
// A result strobes on done_o once its accepted index has passed the whole pipeline.
// Throughput: one index per cycle; busy stays low and start may be held high.
// A 16-cell phase divider chain and a 16-cell CORDIC chain, each cell registered.
// Reset: window_kind clears to rectangular, length_minus_one to 1023, pipe empties.
// Results cannot be stalled; done_o is a single-cycle strobe per word.
`include "assert_macros.svh"

module window_coefficient_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [wcg_pkg::LEN_W-1:0]    sample_index_i,
  output logic                         done_o,
  output logic [wcg_pkg::WEIGHT_W-1:0] weight_o,
  output logic                         index_out_of_range_o,
  input  logic                         cfg_we_i,
  input  logic [wcg_pkg::REG_W-1:0]    cfg_idx_i,
  input  logic [wcg_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import wcg_pkg::*;

  kind_e            kind_q;
  logic [LEN_W-1:0] len_q;

  logic             accept;
  logic             vld_s0_q;
  ctl_t             ctl_s0_d, ctl_s0_q;
  div_t             div_s0_d, div_s0_q;

  logic             div_vld [PHASE_W+1];
  ctl_t             div_ctl [PHASE_W+1];
  div_t             div_dat [PHASE_W+1];

  logic [PHASE_W-1:0] p1, p2, p3;
  lanes_t             lanes_ph_d, lanes_ph_q;
  ctl_t               ctl_ph_q;
  logic               vld_ph_q;

  logic             cor_vld [STEPS+1];
  ctl_t             cor_ctl [STEPS+1];
  lanes_t           cor_dat [STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_RECT;
      len_q  <= LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_KIND: kind_q <= kind_e'(cfg_wdata_i[1:0]);
        REG_LENGTH:      len_q  <= cfg_wdata_i[LEN_W-1:0];
      endcase
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ctl_s0_d.oor     = sample_index_i > len_q;
    ctl_s0_d.at_end  = sample_index_i == len_q;
    ctl_s0_d.kind    = kind_q;
    div_s0_d.divisor = len_q;
    div_s0_d.rem     = (sample_index_i < len_q) ? sample_index_i : '0;
    div_s0_d.num     = PHASE_W'(len_q[LEN_W-1:1]);
    div_s0_d.quot    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s0_q <= 1'b0;
      vld_ph_q <= 1'b0;
    end else begin
      vld_s0_q <= accept;
      vld_ph_q <= div_vld[PHASE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_s0_q   <= ctl_s0_d;
    div_s0_q   <= div_s0_d;
    ctl_ph_q   <= div_ctl[PHASE_W];
    lanes_ph_q <= lanes_ph_d;
  end

  assign div_vld[0] = vld_s0_q;
  assign div_ctl[0] = ctl_s0_q;
  assign div_dat[0] = div_s0_q;

  for (genvar i = 0; i < PHASE_W; i++) begin : g_div
    wcg_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (div_vld[i]),
      .ctl_i  (div_ctl[i]),
      .div_i  (div_dat[i]),
      .vld_o  (div_vld[i+1]),
      .ctl_o  (div_ctl[i+1]),
      .div_o  (div_dat[i+1])
    );
  end

  always_comb begin
    p1 = div_ctl[PHASE_W].at_end ? '0 : div_dat[PHASE_W].quot;
    p2 = {p1[PHASE_W-2:0], 1'b0};
    p3 = p1 + p2;
    lanes_ph_d[0] = lane_init(p1);
    lanes_ph_d[1] = lane_init(p2);
    lanes_ph_d[2] = lane_init(p3);
  end

  assign cor_vld[0] = vld_ph_q;
  assign cor_ctl[0] = ctl_ph_q;
  assign cor_dat[0] = lanes_ph_q;

  for (genvar j = 0; j < STEPS; j++) begin : g_cordic
    wcg_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(j)),
      .vld_i   (cor_vld[j]),
      .ctl_i   (cor_ctl[j]),
      .lanes_i (cor_dat[j]),
      .vld_o   (cor_vld[j+1]),
      .ctl_o   (cor_ctl[j+1]),
      .lanes_o (cor_dat[j+1])
    );
  end

  wcg_weight u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (cor_vld[STEPS]),
    .ctl_i    (cor_ctl[STEPS]),
    .lanes_i  (cor_dat[STEPS]),
    .done_o   (done_o),
    .weight_o (weight_o),
    .oor_o    (index_out_of_range_o)
  );

  `ASSERT_DELAYED(a_latency, start && !busy, LATENCY, done_o)
  `ASSERT_IMPLIES(a_oor_zero, done_o && index_out_of_range_o, weight_o == '0)
  `ASSERT_IMPLIES(a_weight_max, done_o, weight_o <= ONE_Q16)

endmodule
